/* src/des_block_cipher_defines.svh */
// ----------------------------------------------------------------------------
// DES block cipher assertion macros
// Shared property macros for the concurrent checks of the cipher pipeline.
// ----------------------------------------------------------------------------
`ifndef DES_BLOCK_CIPHER_DEFINES_SVH
`define DES_BLOCK_CIPHER_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define DES_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define DES_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/des_pkg.sv */
// ----------------------------------------------------------------------------
// DES package
// Tables, permutations and the round function of the DES cipher.
// ----------------------------------------------------------------------------
package des_pkg;

    localparam int BLOCK_W  = 64;
    localparam int KEY_W    = 64;
    localparam int SUBKEY_W = 48;
    localparam int HALF_W   = 32;
    localparam int CD_W     = 56;
    localparam int ROUNDS   = 16;
    localparam int ADDR_W   = 4;

    localparam logic [ADDR_W-1:0] REG_KEY  = 4'd0;
    localparam logic [ADDR_W-1:0] REG_MODE = 4'd8;

    typedef logic [BLOCK_W-1:0]  t_block;
    typedef logic [SUBKEY_W-1:0] t_subkey;
    typedef logic [HALF_W-1:0]   t_half;
    typedef logic [CD_W-1:0]     t_cd;

    typedef struct packed {
        logic   valid;
        t_half  l;
        t_half  r;
    } t_stage;

    typedef logic [7:0] t_tab64 [64];
    typedef logic [7:0] t_tab56 [56];
    typedef logic [7:0] t_tab48 [48];
    typedef logic [7:0] t_tab32 [32];
    typedef logic [3:0] t_sbox  [8][64];

    localparam t_tab64 TAB_IP = '{
        58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
        62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
        57,49,41,33,25,17,9,1, 59,51,43,35,27,19,11,3,
        61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};
    localparam t_tab64 TAB_FP = '{
        40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
        38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
        36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
        34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};
    localparam t_tab48 TAB_E = '{
        32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
        16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29,
        28,29,30,31,32,1};
    localparam t_tab32 TAB_P = '{
        16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
        2,8,24,14,32,27,3,9, 19,13,30,6,22,11,4,25};
    localparam t_tab56 TAB_PC1 = '{
        57,49,41,33,25,17,9, 1,58,50,42,34,26,18, 10,2,59,51,43,35,27,
        19,11,3,60,52,44,36, 63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
        14,6,61,53,45,37,29, 21,13,5,28,20,12,4};
    localparam t_tab48 TAB_PC2 = '{
        14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8, 16,7,27,20,13,2,
        41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53,
        46,42,50,36,29,32};
    localparam logic [1:0] TAB_ROT [16] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};

    localparam t_sbox TAB_S = '{
        '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
          4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
        '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
          0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
        '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
          13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
        '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
          10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
        '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
          4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
        '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
          9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
        '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
          1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
        '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
          7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

    function automatic t_block perm_ip(input t_block src);
        t_block r;
        for (int i = 0; i < 64; i++) r[63-i] = src[64 - int'(TAB_IP[i])];
        return r;
    endfunction

    function automatic t_block perm_fp(input t_block src);
        t_block r;
        for (int i = 0; i < 64; i++) r[63-i] = src[64 - int'(TAB_FP[i])];
        return r;
    endfunction

    function automatic t_cd perm_pc1(input t_block src);
        t_cd r;
        for (int i = 0; i < 56; i++) r[55-i] = src[64 - int'(TAB_PC1[i])];
        return r;
    endfunction

    function automatic t_subkey perm_pc2(input t_cd src);
        t_subkey r;
        for (int i = 0; i < 48; i++) r[47-i] = src[56 - int'(TAB_PC2[i])];
        return r;
    endfunction

    function automatic logic [27:0] rot28(input logic [27:0] v, input logic [1:0] s);
        return (s == 2'd1) ? {v[26:0], v[27]} : {v[25:0], v[27:26]};
    endfunction

    function automatic t_half feistel(input t_half r, input t_subkey k);
        t_subkey x;
        t_half   f;
        t_half   p;
        logic [5:0] b;
        for (int i = 0; i < 48; i++) x[47-i] = r[32 - int'(TAB_E[i])];
        x = x ^ k;
        for (int j = 0; j < 8; j++) begin
            b = x[47-6*j -: 6];
            f[31-4*j -: 4] = TAB_S[j][{b[5], b[0], b[4:1]}];
        end
        for (int i = 0; i < 32; i++) p[31-i] = f[32 - int'(TAB_P[i])];
        return p;
    endfunction

endpackage

/* src/des_keysched.sv */
// ----------------------------------------------------------------------------
// DES key schedule
// Registers the sixteen round subkeys, ordered for the selected direction.
// ----------------------------------------------------------------------------
module des_keysched (
    input  logic                 i_clk,
    input  logic [63:0]          i_key,
    input  logic                 i_decrypt,
    output des_pkg::t_subkey     o_subkey [16]
);
    import des_pkg::*;

    t_subkey r_subkey [16];
    t_subkey n_subkey [16];
    t_subkey w_sub    [16];
    logic [27:0] w_c;
    logic [27:0] w_d;
    t_cd         w_cd;

    always_comb begin
        w_cd = perm_pc1(i_key);
        w_c  = w_cd[55:28];
        w_d  = w_cd[27:0];
        for (int i = 0; i < 16; i++) begin
            w_c = rot28(w_c, TAB_ROT[i]);
            w_d = rot28(w_d, TAB_ROT[i]);
            w_sub[i] = perm_pc2({w_c, w_d});
        end
        for (int i = 0; i < 16; i++) begin
            n_subkey[i] = i_decrypt ? w_sub[15-i] : w_sub[i];
        end
    end

    always_ff @(posedge i_clk) begin
        r_subkey <= n_subkey;
    end

    assign o_subkey = r_subkey;
endmodule

/* src/des_round.sv */
// ----------------------------------------------------------------------------
// DES round stage
// One registered Feistel round with stall support.
// ----------------------------------------------------------------------------
module des_round (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  des_pkg::t_stage   i_stage,
    input  des_pkg::t_subkey  i_subkey,
    output des_pkg::t_stage   o_stage
);
    import des_pkg::*;

    t_stage r_stage;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (i_en) begin
            r_stage.valid <= i_stage.valid;
        end
        if (i_en) begin
            r_stage.l <= i_stage.r;
            r_stage.r <= i_stage.l ^ feistel(i_stage.r, i_subkey);
        end
    end

    assign o_stage = r_stage;
endmodule

/* src/des_block_cipher.sv */
// ----------------------------------------------------------------------------
// DES block cipher
// Pipelined DES engine with stream ports and APB registers.
// ----------------------------------------------------------------------------
// Usage: the key register is 64 bits wide, so registers lie at 8*i: the key
// at address 0 and decrypt_mode at address 8. Each s_axis beat carries one
// 64-bit block and each m_axis beat returns its cipher result, in order.
// The pipeline has one input stage with IP, sixteen round stages, and one
// output stage with FP. One block is taken every cycle while the output
// register is not full and stalled.
// Subkeys are registered in the key schedule from the key and mode registers.
// When the receiver deasserts tready while the output register is full, the
// whole pipeline holds; input beats are refused only when the output register is full and stalled.
// Reset clears all valid bits and the key and mode registers to zero.
// ----------------------------------------------------------------------------
`include "des_block_cipher_defines.svh"

module des_block_cipher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // block_in[63:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata    // block_out[63:0]
);
    import des_pkg::*;

    logic [63:0] r_key;
    logic        r_mode;
    logic        w_wr;
    logic        w_en;
    t_subkey     w_subkey [16];
    t_stage      w_stage  [17];
    t_stage      r_in;
    logic        r_out_valid;
    t_block      r_out_data;
    t_block      w_ip;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key  <= '0;
            r_mode <= 1'b0;
        end else if (w_wr) begin
            if (paddr == REG_KEY)  r_key  <= pwdata;
            if (paddr == REG_MODE) r_mode <= pwdata[0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == REG_KEY)  prdata = r_key;
        if (paddr == REG_MODE) prdata = {63'd0, r_mode};
    end

    des_keysched u_keysched (
        .i_clk     (i_clk),
        .i_key     (r_key),
        .i_decrypt (r_mode),
        .o_subkey  (w_subkey)
    );

    assign w_en          = !r_out_valid || m_axis_tready;
    assign s_axis_tready = w_en;
    assign w_ip          = perm_ip(s_axis_tdata);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in.valid <= 1'b0;
        end else if (w_en) begin
            r_in.valid <= s_axis_tvalid;
        end
        if (w_en) begin
            r_in.l <= w_ip[63:32];
            r_in.r <= w_ip[31:0];
        end
    end

    assign w_stage[0] = r_in;

    for (genvar g = 0; g < ROUNDS; g++) begin : g_round
        des_round u_round (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (w_en),
            .i_stage  (w_stage[g]),
            .i_subkey (w_subkey[g]),
            .o_stage  (w_stage[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_stage[ROUNDS].valid;
        end
        if (w_en) begin
            r_out_data <= perm_fp({w_stage[ROUNDS].r, w_stage[ROUNDS].l});
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    `DES_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "stalled output changed")
    `DES_ASSERT_IMP(a_ready, i_clk, i_rst_n, !m_axis_tvalid, s_axis_tready,
        "input refused with empty output")
    `DES_ASSERT_NEXT(a_enter, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready,
        w_stage[0].valid, "accepted block not in first stage")
endmodule
